// ===== design/nibble_cascade_irq_timer_top_macros.svh =====
// assertion helpers used by nct_core
`ifndef NIBBLE_CASCADE_IRQ_TIMER_TOP_MACROS_SVH
`define NIBBLE_CASCADE_IRQ_TIMER_TOP_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define NCT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define NCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/nct_pkg.sv =====
package nct_pkg;

    localparam int unsigned PRESCALE_W = 8;
    localparam int unsigned NIBBLE_W   = 4;
    localparam int unsigned EDGE_BIT   = 6;

    localparam logic [NIBBLE_W-1:0] NIBBLE_MAX = 4'hF;

    // command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // timer register indexes
    localparam logic [1:0] REG_STOP   = 2'd0;
    localparam logic [1:0] REG_ACK    = 2'd1;
    localparam logic [1:0] REG_START  = 2'd2;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic       command;
        logic [1:0] reg_index;
        logic [7:0] write_data;
    } t_item;

    typedef struct packed {
        logic                irq_request;
        logic [NIBBLE_W-1:0] count_low;
        logic [NIBBLE_W-1:0] count_high;
    } t_result;

endpackage

// ===== design/nibble_cascade_irq_timer_top.sv =====
// Cascaded-nibble interrupt timer. Each request on the slave side is either one
// CPU cycle tick (tuser = 0) or a write to timer register 0..3 (tuser = 1):
// 0 stops counting, 2 starts it, 1 clears the interrupt and, while stopped,
// loads the low/high counter nibbles from the data byte; 3 does nothing. Ticks
// drive an 8-bit prescaler; each rise of its bit 6 steps the low nibble, which
// carries into the high nibble at 15; both at 15 raise the interrupt, which
// holds the prescaler at zero until cleared. Every request yields exactly one
// result request carrying the interrupt level and both nibbles after that step.
// Throughput is one request per clock cycle while the receiver takes results
// without stalling; a request passes through the input register, then the
// result register, before its result is offered, and it waits in the input
// register while the result slot is full and not being drained.
module nibble_cascade_irq_timer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [1:0] reg_index, [9:2] write_data, rest zero
    input  logic        s_axis_tuser,  // [0] command
    // master side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // [0] irq_request, [4:1] count_low,
                                       // [8:5] count_high, rest zero
);

    // input register
    logic           r_in_valid;
    nct_pkg::t_item r_in_item;
    // result register
    logic             r_out_valid;
    nct_pkg::t_result r_out_result;

    logic             w_advance;
    logic             w_in_accept;
    nct_pkg::t_result w_result;

    // the held request moves on when the result slot is free or being drained
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_item.command    <= s_axis_tuser;
            r_in_item.reg_index  <= s_axis_tdata[1:0];
            r_in_item.write_data <= s_axis_tdata[9:2];
        end
    end

    // timer state and next-state logic
    nct_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (r_in_item),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_result <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_result.count_high, r_out_result.count_low,
                            r_out_result.irq_request};

endmodule

// ===== design/nct_core.sv =====
module nct_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_advance,
    input  nct_pkg::t_item  i_item,
    output nct_pkg::t_result o_result
);

    `include "nibble_cascade_irq_timer_top_macros.svh"

    logic [nct_pkg::PRESCALE_W-1:0] r_prescale, n_prescale;
    logic                           r_enabled,  n_enabled;
    logic [nct_pkg::NIBBLE_W-1:0]   r_low,      n_low;
    logic [nct_pkg::NIBBLE_W-1:0]   r_high,     n_high;
    logic                           r_pending,  n_pending;

    logic [nct_pkg::PRESCALE_W-1:0] w_pre_next;
    logic [nct_pkg::NIBBLE_W-1:0]   w_low_inc;
    logic [nct_pkg::NIBBLE_W-1:0]   w_high_inc;
    logic                           w_edge;

    assign w_pre_next = r_pending ? '0 : r_prescale + 1'b1;
    assign w_edge     = r_enabled && !r_prescale[nct_pkg::EDGE_BIT]
                        && w_pre_next[nct_pkg::EDGE_BIT];
    assign w_low_inc  = r_low + 1'b1;
    assign w_high_inc = r_high + 1'b1;

    always_comb begin
        n_prescale = r_prescale;
        n_enabled  = r_enabled;
        n_low      = r_low;
        n_high     = r_high;
        n_pending  = r_pending;
        if (i_item.command == nct_pkg::CMD_TICK) begin
            n_prescale = w_pre_next;
            if (w_edge) begin
                n_low = w_low_inc;
                if (w_low_inc == nct_pkg::NIBBLE_MAX) begin
                    n_high = w_high_inc;
                    if (w_high_inc == nct_pkg::NIBBLE_MAX) begin
                        n_pending = 1'b1;
                    end
                end
            end
        end else begin
            case (i_item.reg_index)
                nct_pkg::REG_STOP: begin
                    n_enabled = 1'b0;
                end
                nct_pkg::REG_ACK: begin
                    if (!r_enabled) begin
                        n_low  = i_item.write_data[3:0];
                        n_high = i_item.write_data[7:4];
                    end
                    n_pending = 1'b0;
                end
                nct_pkg::REG_START: begin
                    n_enabled = 1'b1;
                end
                nct_pkg::REG_UNUSED: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale <= '0;
            r_enabled  <= 1'b0;
            r_low      <= '0;
            r_high     <= '0;
            r_pending  <= 1'b0;
        end else if (i_advance) begin
            r_prescale <= n_prescale;
            r_enabled  <= n_enabled;
            r_low      <= n_low;
            r_high     <= n_high;
            r_pending  <= n_pending;
        end
    end

    assign o_result.irq_request = n_pending;
    assign o_result.count_low   = n_low;
    assign o_result.count_high  = n_high;

    `NCT_ASSERT_NEXT(a_pending_holds_prescaler,
        i_advance && i_item.command == nct_pkg::CMD_TICK && r_pending,
        r_prescale == '0, "prescaler moved while interrupt pending")
    `NCT_ASSERT_NEXT(a_write_keeps_prescaler,
        i_advance && i_item.command == nct_pkg::CMD_WRITE,
        $stable(r_prescale), "register write changed the prescaler")
    `NCT_ASSERT_NEXT(a_no_load_while_counting,
        i_advance && i_item.command == nct_pkg::CMD_WRITE
            && i_item.reg_index == nct_pkg::REG_ACK && r_enabled,
        $stable(r_low) && $stable(r_high), "counters loaded while counting")
    `NCT_ASSERT_NOW(a_pending_rises_at_terminal,
        $rose(r_pending),
        r_low == nct_pkg::NIBBLE_MAX && r_high == nct_pkg::NIBBLE_MAX,
        "interrupt raised before both nibbles reached terminal count")

endmodule

// ===== test/nct_timer_checker.sv =====
// watches both stream channels, predicts each result and compares in order
module nct_timer_checker
    import nct_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // [1:0] reg_index, [9:2] write_data, rest zero
    input  logic        i_s_axis_tuser,  // [0] command
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [15:0] i_m_axis_tdata,  // [0] irq_request, [4:1] count_low, [8:5] count_high
    output int          o_fail_count,
    output int          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // timer state as the predictor sees it
    logic [PRESCALE_W-1:0] prescaler;
    logic                  counting_on;
    logic [NIBBLE_W-1:0]   low_nib;
    logic [NIBBLE_W-1:0]   high_nib;
    logic                  irq_pending;

    t_result expected_counts_q[$];

    function automatic t_result timer_step(input t_item req);
        logic [PRESCALE_W-1:0] prev;
        t_result               res;
        if (req.command == CMD_WRITE) begin
            case (req.reg_index)
                REG_STOP: counting_on = 1'b0;
                REG_ACK: begin
                    // nibbles load only while stopped, the clear always happens
                    if (!counting_on) begin
                        low_nib  = req.write_data[3:0];
                        high_nib = req.write_data[7:4];
                    end
                    irq_pending = 1'b0;
                end
                REG_START: counting_on = 1'b1;
                default: ;
            endcase
        end else begin
            prev      = prescaler;
            prescaler = irq_pending ? '0 : prescaler + 1'b1;
            if (counting_on && !prev[EDGE_BIT] && prescaler[EDGE_BIT]) begin
                low_nib = low_nib + 1'b1;
                if (low_nib == NIBBLE_MAX) begin
                    high_nib = high_nib + 1'b1;
                    if (high_nib == NIBBLE_MAX) irq_pending = 1'b1;
                end
            end
        end
        res.irq_request = irq_pending;
        res.count_low   = low_nib;
        res.count_high  = high_nib;
        return res;
    endfunction

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_item   req;
        t_result got;
        t_result exp;
        if (!i_rst_n) begin
            prescaler   = '0;
            counting_on = 1'b0;
            low_nib     = '0;
            high_nib    = '0;
            irq_pending = 1'b0;
            expected_counts_q.delete();
        end else begin
            // results first: a request never shows up in the same cycle it went in
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.irq_request = i_m_axis_tdata[0];
                got.count_low   = i_m_axis_tdata[4:1];
                got.count_high  = i_m_axis_tdata[8:5];
                if (expected_counts_q.size() == 0) begin
                    $display("%0t: unexpected result irq=%b low=%h high=%h", $time,
                             got.irq_request, got.count_low, got.count_high);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp = expected_counts_q.pop_front();
                    if (got !== exp) begin
                        $display("%0t: mismatch expected irq=%b low=%h high=%h, got irq=%b low=%h high=%h",
                                 $time, exp.irq_request, exp.count_low, exp.count_high,
                                 got.irq_request, got.count_low, got.count_high);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                req.command    = i_s_axis_tuser;
                req.reg_index  = i_s_axis_tdata[1:0];
                req.write_data = i_s_axis_tdata[9:2];
                expected_counts_q.push_back(timer_step(req));
            end
        end
        o_outstanding <= expected_counts_q.size();
    end

endmodule

// ===== test/nibble_cascade_irq_timer_top_tb.sv =====
// stimulus and verdict for the nibble cascade interrupt timer
module nibble_cascade_irq_timer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import nct_pkg::*;

    localparam int RANDOM_REQUESTS = 1300;
    localparam int QUIET_LIMIT     = 3000;  // cycles without any handshake
    localparam int LONG_HOLD       = 80;    // receiver hold-off used to back up the block

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;  // [1:0] reg_index, [9:2] write_data, rest zero
    logic        s_axis_tuser  = 1'b0; // [0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [0] irq_request, [4:1] count_low, [8:5] count_high

    int fail_count;
    int outstanding;

    // idle percentages, changed per phase by the sender
    int send_idle_pct = 34;
    int recv_idle_pct = 51;
    bit hold_request  = 1'b0;
    int random_sent   = 0;
    int phase         = 0;

    nibble_cascade_irq_timer_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    nct_timer_checker timer_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding)
    );

    // 12 ns clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver: random stalls, plus one long hold-off when asked for
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                stall_left = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // watchdog: ends the run if the channels go quiet for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("nibble_cascade_irq_timer_top_tb failed");
        $finish;
    end

    // offer one request, with random idle cycles first; returns at the
    // falling edge after the handshake
    task automatic offer_request(input logic cmd, input logic [1:0] reg_sel,
                                 input logic [7:0] data);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {6'b0, data, reg_sel};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // tick with random contents in the ignored fields
    task automatic offer_tick();
        offer_request(CMD_TICK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    endtask

    // stop sending until every expected result has come back
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (outstanding != 0) @(negedge i_clk);
    endtask

    // switch idle pattern as the random part moves on
    task automatic update_phase();
        if (phase == 0 && random_sent >= RANDOM_REQUESTS / 3) begin
            phase = 1;
            wait_for_results();
            send_idle_pct = 51;
            recv_idle_pct = 34;
        end else if (phase == 1 && random_sent >= 2 * RANDOM_REQUESTS / 3) begin
            phase = 2;
            wait_for_results();
            send_idle_pct = 0;
            recv_idle_pct = 0;
            // back up the block while the sender keeps offering
            hold_request = 1'b1;
        end
    endtask

    initial begin
        int burst;
        int pick;
        logic [7:0] load_val;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part
        offer_request(CMD_TICK, REG_UNUSED, 8'hFF);   // ignored fields set on a tick
        offer_request(CMD_WRITE, REG_UNUSED, 8'hFF);  // unused register
        offer_request(CMD_WRITE, REG_ACK, 8'hFF);     // load while stopped, both at max
        offer_request(CMD_TICK, REG_STOP, 8'h00);
        offer_request(CMD_WRITE, REG_ACK, 8'h00);     // load zeros
        offer_request(CMD_WRITE, REG_ACK, 8'hEE);     // one step away from the interrupt
        offer_request(CMD_WRITE, REG_START, 8'h00);
        offer_request(CMD_TICK, REG_START, 8'hAA);
        offer_request(CMD_WRITE, REG_ACK, 8'h5A);     // load ignored while counting
        offer_request(CMD_TICK, REG_ACK, 8'h55);
        offer_request(CMD_WRITE, REG_STOP, 8'hFF);
        offer_request(CMD_WRITE, REG_ACK, 8'hA5);
        offer_request(CMD_TICK, REG_UNUSED, 8'h00);
        offer_request(CMD_WRITE, REG_START, 8'hFF);
        offer_request(CMD_WRITE, REG_START, 8'h00);   // start while already counting
        offer_request(CMD_WRITE, REG_STOP, 8'h00);
        offer_request(CMD_WRITE, REG_STOP, 8'h00);    // stop while already stopped
        offer_request(CMD_WRITE, REG_UNUSED, 8'h00);
        offer_request(CMD_TICK, REG_UNUSED, 8'h00);
        wait_for_results();

        // random part: mostly load/start/run sequences, some noise
        while (random_sent < RANDOM_REQUESTS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                // mostly loads close to the interrupt so it actually fires
                pick = $urandom_range(0, 99);
                if (pick < 50)      load_val = 8'hEE;
                else if (pick < 70) load_val = {4'hE, 4'($urandom_range(12, 15))};
                else                load_val = 8'($urandom_range(0, 255));
                offer_request(CMD_WRITE, REG_STOP, 8'($urandom_range(0, 255)));
                offer_request(CMD_WRITE, REG_ACK, load_val);
                offer_request(CMD_WRITE, REG_START, 8'($urandom_range(0, 255)));
                random_sent += 3;
                burst = $urandom_range(16, 260);
                // long tick runs cover prescaler wrap and the pending hold
                repeat (burst) begin
                    if ($urandom_range(0, 99) < 3)
                        offer_request(CMD_WRITE, REG_ACK, 8'($urandom_range(0, 255)));
                    else
                        offer_tick();
                    random_sent++;
                    update_phase();
                end
                if ($urandom_range(0, 1)) begin
                    offer_request(CMD_WRITE, REG_ACK, 8'($urandom_range(0, 255)));
                    random_sent++;
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    offer_request(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                                  8'($urandom_range(0, 255)));
                    random_sent++;
                end
            end
            update_phase();
        end

        s_axis_tvalid <= 1'b0;
        while (outstanding != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (fail_count == 0 && outstanding == 0)
            $display("nibble_cascade_irq_timer_top_tb passed");
        else
            $display("nibble_cascade_irq_timer_top_tb failed");
        $finish;
    end

endmodule
